### rtl/core/ews_pkg.sv
// shared constants, types and tables for the epicycle waveshaper
package ews_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 12;

  localparam int LVL_W = 13;
  localparam logic [LVL_W-1:0] LVL_ONE  = 13'd4096;
  localparam logic [LVL_W-1:0] LVL_HALF = 13'd2048;

  localparam int CORDIC_STEPS = 28;
  localparam int ANG_W  = 32;
  localparam int CX_W   = 62;
  localparam int NUM_W  = 58;
  localparam int SH_W   = 6;
  localparam int DIV_W  = 64;
  localparam int NORM_TOP = 57;
  localparam int MIX_STAGES = 6;
  localparam int COMB_STAGES = 5;

  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 32'sd536870912;
  localparam logic signed [ANG_W-1:0] ANG_PI      = 32'sd1073741824;
  localparam logic [23:0] INV_GAIN_Q24 = 24'd10188015;
  localparam logic [15:0] THIRD_Q16    = 16'd21823;
  localparam logic [14:0] GAIN_RESET   = 15'd4096;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ALGORITHM = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_EQUANT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BLEND     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEMOD     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN      = 3'd4;

  localparam logic [1:0] ALG_CHAIN = 2'd0;
  localparam logic [1:0] ALG_PAIR  = 2'd1;
  localparam logic [1:0] ALG_SPLIT = 2'd2;
  localparam logic [1:0] ALG_STAR  = 2'd3;

  typedef struct packed {
    logic              zero;
    logic              xneg;
    logic              xzero;
    logic              yzero;
    logic              ypos;
    logic              yneg;
    logic [SH_W-1:0]   n;
    logic [NUM_W-1:0]  num;
    logic [LVL_W-1:0]  env;
  } vec_side_t;

  typedef struct packed {
    logic signed [CX_W-1:0]  xn;
    logic signed [CX_W-1:0]  yn;
    logic signed [ANG_W-1:0] z;
    vec_side_t               side;
  } cordic_st_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [LVL_W-1:0] lvl_clamp(input logic [LVL_W-1:0] v);
    return (v > LVL_ONE) ? LVL_ONE : v;
  endfunction

  function automatic logic signed [ANG_W-1:0] atan_step(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0:  r = 32'sd268435456;
      1:  r = 32'sd158466703;
      2:  r = 32'sd83729454;
      3:  r = 32'sd42502378;
      4:  r = 32'sd21333666;
      5:  r = 32'sd10677233;
      6:  r = 32'sd5339919;
      7:  r = 32'sd2670123;
      8:  r = 32'sd1335082;
      9:  r = 32'sd667543;
      10: r = 32'sd333772;
      11: r = 32'sd166886;
      12: r = 32'sd83443;
      13: r = 32'sd41722;
      14: r = 32'sd20861;
      15: r = 32'sd10430;
      16: r = 32'sd5215;
      17: r = 32'sd2608;
      18: r = 32'sd1304;
      19: r = 32'sd652;
      20: r = 32'sd326;
      21: r = 32'sd163;
      22: r = 32'sd81;
      23: r = 32'sd41;
      24: r = 32'sd20;
      25: r = 32'sd10;
      26: r = 32'sd5;
      27: r = 32'sd3;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/epicycle_waveshaper_top.sv
// epicycle waveshaper top level: body chaining, three body lanes, final mix and gain
// throughput: one sample per cycle, busy is low whenever reset is low
// depth is set by the 28-stage cordic and the FRAC_BITS+2 stage restoring divider
// reset clears every valid bit and returns the configuration registers to their reset values
// results appear on sample_out for one cycle with done; the receiver cannot stall
module epicycle_waveshaper_top
  import ews_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  output logic                                      busy,
  input  logic signed [SAMPLE_WIDTH-1:0]            osc1_x,
  input  logic signed [SAMPLE_WIDTH-1:0]            osc1_y,
  input  logic signed [SAMPLE_WIDTH-1:0]            osc2_x,
  input  logic signed [SAMPLE_WIDTH-1:0]            osc2_y,
  input  logic signed [SAMPLE_WIDTH-1:0]            osc3_x,
  input  logic signed [SAMPLE_WIDTH-1:0]            osc3_y,
  input  logic signed [SAMPLE_WIDTH-1:0]            osc4_x,
  input  logic signed [SAMPLE_WIDTH-1:0]            osc4_y,
  input  logic [LVL_W-1:0]                          env_level_2,
  input  logic [LVL_W-1:0]                          env_level_3,
  input  logic [LVL_W-1:0]                          env_level_4,
  input  logic                                      cfg_we,
  input  logic [REG_IDX_W-1:0]                      cfg_index,
  input  logic [max_int(SAMPLE_WIDTH, 15)-1:0]      cfg_data,
  output logic                                      done,
  output logic signed [SAMPLE_WIDTH-1:0]            sample_out
);

  localparam int W     = SAMPLE_WIDTH;
  localparam int CW    = W + 3;
  localparam int SW    = FRAC_BITS + 3;
  localparam int DW    = W + 4;
  localparam int MW    = max_int(SW, DW) + 14;
  localparam int TW    = MW + 2;
  localparam int VW    = TW - 11;
  localparam int GW    = VW + 16;
  localparam int VEC_STAGES = CORDIC_STEPS + 5 + FRAC_BITS + 2;
  localparam int LATENCY    = 1 + VEC_STAGES + MIX_STAGES + COMB_STAGES;
  localparam logic signed [GW-1:0] SAT_HI = {{(GW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [GW-1:0] SAT_LO = {{(GW-W+1){1'b1}}, {(W-1){1'b0}}};

  assign busy = rst;

  // configuration registers
  logic [1:0]             algorithm;
  logic signed [W-1:0]    equant_offset;
  logic [LVL_W-1:0]       blend_amount;
  logic [LVL_W-1:0]       demod_mix;
  logic [14:0]            output_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm     <= ALG_CHAIN;
      equant_offset <= '0;
      blend_amount  <= '0;
      demod_mix     <= '0;
      output_gain   <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALGORITHM: algorithm     <= cfg_data[1:0];
        REG_EQUANT:    equant_offset <= cfg_data[W-1:0];
        REG_BLEND:     blend_amount  <= cfg_data[LVL_W-1:0];
        REG_DEMOD:     demod_mix     <= cfg_data[LVL_W-1:0];
        REG_GAIN:      output_gain   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // body chaining
  logic signed [CW-1:0] o1x, o1y, o2x, o2y, o3x, o3y, o4x, o4y, eq;
  logic signed [CW-1:0] b1x, b1y, b2x, b2y, b3x, b3y, b4x, b4y;
  logic                 in_beat;

  assign in_beat = start && !busy;

  always_comb begin
    o1x = {{3{osc1_x[W-1]}}, osc1_x};
    o1y = {{3{osc1_y[W-1]}}, osc1_y};
    o2x = {{3{osc2_x[W-1]}}, osc2_x};
    o2y = {{3{osc2_y[W-1]}}, osc2_y};
    o3x = {{3{osc3_x[W-1]}}, osc3_x};
    o3y = {{3{osc3_y[W-1]}}, osc3_y};
    o4x = {{3{osc4_x[W-1]}}, osc4_x};
    o4y = {{3{osc4_y[W-1]}}, osc4_y};
    eq  = {{3{equant_offset[W-1]}}, equant_offset};
    b1x = o1x;
    b1y = o1y;
    b2x = b1x + o2x;
    b2y = b1y + o2y;
    if (algorithm == ALG_CHAIN || algorithm == ALG_PAIR) begin
      b3x = b2x + o3x;
      b3y = b2y + o3y;
    end else begin
      b3x = b1x + o3x;
      b3y = b1y + o3y;
    end
    case (algorithm)
      ALG_CHAIN, ALG_SPLIT: begin
        b4x = b3x + o4x;
        b4y = b3y + o4y;
      end
      ALG_PAIR: begin
        b4x = b2x + o4x;
        b4y = b2y + o4y;
      end
      default: begin
        b4x = b1x + o4x;
        b4y = b1y + o4y;
      end
    endcase
  end

  logic                 lane_in_vld;
  logic signed [CW-1:0] lane_x   [3];
  logic signed [CW-1:0] lane_y   [3];
  logic [LVL_W-1:0]     lane_env [3];

  always_ff @(posedge clk) begin
    if (rst) lane_in_vld <= 1'b0;
    else     lane_in_vld <= in_beat;
  end

  always_ff @(posedge clk) begin
    lane_x[0]   <= b4x;
    lane_y[0]   <= b4y + eq;
    lane_env[0] <= env_level_4;
    lane_x[1]   <= b3x;
    lane_y[1]   <= b3y + eq;
    lane_env[1] <= env_level_3;
    lane_x[2]   <= b2x;
    lane_y[2]   <= b2y + eq;
    lane_env[2] <= env_level_2;
  end

  // body lanes
  logic                 mix_vld [3];
  logic signed [MW-1:0] mix_val [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic                 v_vld;
    logic signed [SW-1:0] v_sine, v_square, v_saw;
    logic signed [DW-1:0] v_dist;
    logic [LVL_W-1:0]     v_env;

    ews_vec #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
    ) u_vec (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (lane_in_vld),
      .x       (lane_x[l]),
      .y       (lane_y[l]),
      .env     (lane_env[l]),
      .out_vld (v_vld),
      .sine    (v_sine),
      .square  (v_square),
      .saw     (v_saw),
      .radius  (v_dist),
      .out_env (v_env)
    );

    ews_mix #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
    ) u_mix (
      .clk          (clk),
      .rst          (rst),
      .in_vld       (v_vld),
      .sine         (v_sine),
      .square       (v_square),
      .saw          (v_saw),
      .radius       (v_dist),
      .env          (v_env),
      .blend_amount (blend_amount),
      .demod_mix    (demod_mix),
      .out_vld      (mix_vld[l]),
      .mix          (mix_val[l])
    );
  end

  // final combine
  logic [4:1]             cv;
  logic signed [TW-1:0]   tot;
  logic signed [VW-1:0]   v1, v2;
  logic signed [VW+16:0]  p3;
  logic signed [GW-1:0]   g4, r5;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv   <= '0;
      done <= 1'b0;
    end else begin
      cv   <= {cv[3:1], mix_vld[0]};
      done <= cv[4];
    end
  end

  always_ff @(posedge clk) begin
    tot <= TW'(mix_val[0])
         + ((algorithm == ALG_PAIR || algorithm == ALG_STAR) ? TW'(mix_val[1]) : '0)
         + ((algorithm == ALG_SPLIT || algorithm == ALG_STAR) ? TW'(mix_val[2]) : '0);
  end

  logic signed [VW-1:0] vr;
  assign vr = VW'((tot + 2048) >>> 12);

  always_ff @(posedge clk) begin
    v1 <= vr;
    p3 <= vr * $signed({1'b0, THIRD_Q16});
  end

  always_ff @(posedge clk) begin
    case (algorithm)
      ALG_CHAIN:           v2 <= v1;
      ALG_PAIR, ALG_SPLIT: v2 <= VW'((v1 + 1) >>> 1);
      ALG_STAR:            v2 <= VW'((p3 + 32768) >>> 16);
      default:             v2 <= v1;
    endcase
  end

  always_ff @(posedge clk) begin
    g4 <= v2 * $signed({1'b0, output_gain});
  end

  assign r5 = (g4 + 2048) >>> 12;

  always_ff @(posedge clk) begin
    if (r5 > SAT_HI)      sample_out <= W'(SAT_HI);
    else if (r5 < SAT_LO) sample_out <= W'(SAT_LO);
    else                  sample_out <= W'(r5);
  end

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    (mix_vld[0] == mix_vld[1]) && (mix_vld[0] == mix_vld[2]))
    else $error("body lanes out of step");

  a_beat_to_done: assert property (@(posedge clk) disable iff (rst)
    in_beat |-> ##LATENCY done)
    else $error("accepted beat gave no result");

  a_done_from_beat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_beat, LATENCY))
    else $error("result without an accepted beat");

endmodule

### rtl/core/ews_vec.sv
// per-body vector analysis: normalise, cordic angle and length, divider for sine
module ews_vec
  import ews_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  logic signed [SAMPLE_WIDTH+2:0] x,
  input  logic signed [SAMPLE_WIDTH+2:0] y,
  input  logic [LVL_W-1:0]              env,
  output logic                          out_vld,
  output logic signed [FRAC_BITS+2:0]   sine,
  output logic signed [FRAC_BITS+2:0]   square,
  output logic signed [FRAC_BITS+2:0]   saw,
  output logic signed [SAMPLE_WIDTH+3:0] radius,
  output logic [LVL_W-1:0]              out_env
);

  localparam int CW     = SAMPLE_WIDTH + 3;
  localparam int DW     = CW + 1;
  localparam int QB     = FRAC_BITS + 2;
  localparam int SW     = FRAC_BITS + 3;
  localparam int SAW_SH = 29 - FRAC_BITS;
  localparam int RN_W   = CX_W - 24 + 25;
  localparam logic signed [SW-1:0] ONE = SW'(1 << FRAC_BITS);

  typedef struct packed {
    logic [DIV_W-1:0]        rem;
    logic [DIV_W-1:0]        den;
    logic [QB-1:0]           q;
    logic signed [ANG_W-1:0] z;
    logic signed [DW-1:0]    radius;
    vec_side_t               side;
  } div_st_t;

  // normalise stage
  logic [CW-1:0]  ax, ay, mx;
  logic [SH_W-1:0] msb;
  logic           s1_vld;
  logic signed [CW-1:0] s1_x, s1_y;
  logic [CW-1:0]  s1_ay;
  vec_side_t      s1_side;

  always_comb begin
    ax = x[CW-1] ? CW'(-x) : CW'(x);
    ay = y[CW-1] ? CW'(-y) : CW'(y);
    mx = (ax > ay) ? ax : ay;
    msb = '0;
    for (int k = 0; k < CW; k++) begin
      if (mx[k]) msb = SH_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= in_vld;
  end

  always_ff @(posedge clk) begin
    s1_x          <= x;
    s1_y          <= y;
    s1_ay         <= ay;
    s1_side.zero  <= (x == '0) && (y == '0);
    s1_side.xneg  <= x[CW-1];
    s1_side.xzero <= (x == '0);
    s1_side.yzero <= (y == '0);
    s1_side.ypos  <= !y[CW-1] && (y != '0);
    s1_side.yneg  <= y[CW-1];
    s1_side.n     <= SH_W'(NORM_TOP) - msb;
    s1_side.num   <= '0;
    s1_side.env   <= env;
  end

  // shift up and pre-rotate into the right half plane
  logic                   cv [0:CORDIC_STEPS];
  cordic_st_t             cs [0:CORDIC_STEPS];
  logic signed [CX_W-1:0] xs, ys;
  vec_side_t              s0_side;

  always_comb begin
    xs = $signed({{(CX_W-CW){s1_x[CW-1]}}, s1_x}) <<< s1_side.n;
    ys = $signed({{(CX_W-CW){s1_y[CW-1]}}, s1_y}) <<< s1_side.n;
    s0_side     = s1_side;
    s0_side.num = NUM_W'(s1_ay) << s1_side.n;
  end

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else     cv[0] <= s1_vld;
  end

  always_ff @(posedge clk) begin
    cs[0].side <= s0_side;
    if (xs[CX_W-1]) begin
      if (!ys[CX_W-1]) begin
        cs[0].xn <= ys;
        cs[0].yn <= -xs;
        cs[0].z  <= ANG_HALF_PI;
      end else begin
        cs[0].xn <= -ys;
        cs[0].yn <= xs;
        cs[0].z  <= -ANG_HALF_PI;
      end
    end else begin
      cs[0].xn <= xs;
      cs[0].yn <= ys;
      cs[0].z  <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CX_W-1:0] dx, dy;
    assign dx = cs[i].yn >>> i;
    assign dy = cs[i].xn >>> i;

    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else     cv[i+1] <= cv[i];
    end

    always_ff @(posedge clk) begin
      cs[i+1].side <= cs[i].side;
      if (!cs[i].yn[CX_W-1]) begin
        cs[i+1].xn <= cs[i].xn + dx;
        cs[i+1].yn <= cs[i].yn - dy;
        cs[i+1].z  <= cs[i].z + atan_step(i);
      end else begin
        cs[i+1].xn <= cs[i].xn - dx;
        cs[i+1].yn <= cs[i].yn + dy;
        cs[i+1].z  <= cs[i].z - atan_step(i);
      end
    end
  end

  // gain correction multiply and exact angles on the axes
  logic                    m_vld;
  logic signed [RN_W-1:0]  m_rn;
  logic signed [ANG_W-1:0] m_z, zf;
  vec_side_t               m_side;
  logic signed [CX_W-25:0] xh;

  assign xh = cs[CORDIC_STEPS].xn[CX_W-1:24];

  always_comb begin
    zf = cs[CORDIC_STEPS].z;
    if (cs[CORDIC_STEPS].side.yzero) begin
      zf = cs[CORDIC_STEPS].side.xneg ? ANG_PI : '0;
    end else if (cs[CORDIC_STEPS].side.xzero) begin
      zf = cs[CORDIC_STEPS].side.ypos ? ANG_HALF_PI : -ANG_HALF_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_vld <= 1'b0;
    else     m_vld <= cv[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    m_rn   <= xh * $signed({1'b0, INV_GAIN_Q24});
    m_z    <= zf;
    m_side <= cs[CORDIC_STEPS].side;
  end

  // length rounding and divider set-up
  logic                   dv [0:QB];
  div_st_t                ds [0:QB];
  logic signed [RN_W-1:0] rbias, rfull, dq;
  logic [DIV_W-1:0]       den;

  always_comb begin
    rbias = (RN_W'(1) << m_side.n) >>> 1;
    rfull = (m_rn + rbias) >>> m_side.n;
    dq    = m_rn >>> FRAC_BITS;
    den   = (dq <= 0) ? DIV_W'(1) : DIV_W'(dq);
  end

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else     dv[0] <= m_vld;
  end

  always_ff @(posedge clk) begin
    ds[0].rem    <= DIV_W'(m_side.num) + (den >> 1);
    ds[0].den    <= den;
    ds[0].q      <= '0;
    ds[0].z      <= m_z;
    ds[0].radius <= DW'(rfull);
    ds[0].side   <= m_side;
  end

  // restoring divider, one quotient bit a stage
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [DIV_W-1:0] dsh;
    div_st_t          dn;
    assign dsh = ds[j].den << (QB - 1 - j);

    always_comb begin
      dn = ds[j];
      if (ds[j].rem >= dsh) begin
        dn.rem           = ds[j].rem - dsh;
        dn.q[QB - 1 - j] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else     dv[j+1] <= dv[j];
    end

    always_ff @(posedge clk) begin
      ds[j+1] <= dn;
    end
  end

  // wave shapes
  logic [QB-1:0]           qc;
  logic signed [ANG_W-1:0] zr;

  always_comb begin
    qc = (ds[QB].q > QB'(ONE)) ? QB'(ONE) : ds[QB].q;
    zr = (ds[QB].z + ANG_W'(1 << (SAW_SH - 1))) >>> SAW_SH;
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else     out_vld <= dv[QB];
  end

  always_ff @(posedge clk) begin
    out_env <= ds[QB].side.env;
    if (ds[QB].side.zero) begin
      sine   <= '0;
      square <= -ONE;
      saw    <= -ONE;
      radius <= '0;
    end else begin
      sine   <= ds[QB].side.yneg ? -$signed(qc) : $signed(qc);
      square <= (ds[QB].side.ypos || (ds[QB].side.yzero && ds[QB].side.xneg)) ? ONE : -ONE;
      saw    <= SW'(zr) - ONE;
      radius <= ds[QB].radius;
    end
  end

endmodule

### rtl/core/ews_mix.sv
// per-body wave blend and envelope / distance weighting
module ews_mix
  import ews_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_vld,
  input  logic signed [FRAC_BITS+2:0]    sine,
  input  logic signed [FRAC_BITS+2:0]    square,
  input  logic signed [FRAC_BITS+2:0]    saw,
  input  logic signed [SAMPLE_WIDTH+3:0] radius,
  input  logic [LVL_W-1:0]               env,
  input  logic [LVL_W-1:0]               blend_amount,
  input  logic [LVL_W-1:0]               demod_mix,
  output logic                           out_vld,
  output logic signed [max_int(FRAC_BITS+3, SAMPLE_WIDTH+4)+13:0] mix
);

  localparam int SW   = FRAC_BITS + 3;
  localparam int DW   = SAMPLE_WIDTH + 4;
  localparam int PW   = SW + 15;
  localparam int PDW  = SW + DW;
  localparam int MW   = max_int(SW, DW) + 14;

  logic [5:1] vld;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[4:1], in_vld};
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else     out_vld <= vld[5];
  end

  // blend weights
  logic [LVL_W-1:0]     b;
  logic [LVL_W:0]       w1, w2;
  logic signed [SW-1:0] a1, a2;
  logic signed [PW-1:0] p1, p2;
  logic signed [DW-1:0] dist1;
  logic [LVL_W-1:0]     env1;

  always_comb begin
    b = lvl_clamp(blend_amount);
    if (b < LVL_HALF) begin
      w1 = {1'b0, LVL_ONE} - {b, 1'b0};
      w2 = {b, 1'b0};
      a1 = sine;
      a2 = square;
    end else begin
      w1 = {LVL_ONE - b, 1'b0};
      w2 = {b - LVL_HALF, 1'b0};
      a1 = square;
      a2 = saw;
    end
  end

  always_ff @(posedge clk) begin
    p1    <= a1 * $signed({1'b0, w1});
    p2    <= a2 * $signed({1'b0, w2});
    dist1 <= radius;
    env1  <= env;
  end

  // blended sample
  logic signed [PW:0]   psum;
  logic signed [SW-1:0] s2;
  logic signed [DW-1:0] dist2;
  logic [LVL_W-1:0]     env2;

  assign psum = p1 + p2;

  always_ff @(posedge clk) begin
    s2    <= SW'((psum + 2048) >>> 12);
    dist2 <= dist1;
    env2  <= lvl_clamp(env1);
  end

  // weighting products
  logic signed [SW+LVL_W:0] pm;
  logic signed [PDW-1:0]    pd;

  always_ff @(posedge clk) begin
    pm <= s2 * $signed({1'b0, env2});
    pd <= s2 * dist2;
  end

  // rounding, distance weight is three quarters
  logic signed [PDW+1:0] pd3;
  logic signed [SW-1:0]  md;
  logic signed [DW-1:0]  dm4;

  assign pd3 = (PDW+2)'(pd) + ((PDW+2)'(pd) <<< 1);

  always_ff @(posedge clk) begin
    md  <= SW'((pm + 2048) >>> 12);
    dm4 <= DW'((pd3 + (1 << (FRAC_BITS + 1))) >>> (FRAC_BITS + 2));
  end

  // demod crossfade
  logic [LVL_W-1:0]           dmc;
  logic signed [SW+LVL_W:0]   q1;
  logic signed [DW+LVL_W:0]   q2;

  assign dmc = lvl_clamp(demod_mix);

  always_ff @(posedge clk) begin
    q1 <= md * $signed({1'b0, LVL_ONE - dmc});
    q2 <= dm4 * $signed({1'b0, dmc});
  end

  always_ff @(posedge clk) begin
    mix <= MW'(q1) + MW'(q2);
  end

endmodule

### tb/sv/epicycle_waveshaper_top_test.sv
// self-checking testbench for the epicycle waveshaper top level
module epicycle_waveshaper_top_test;
  import ews_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd5;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic signed [15:0] ox [4];
    logic signed [15:0] oy [4];
    logic [LVL_W-1:0]   env [3];
  } orbit_beat_t;

  class sample_scoreboard;
    logic [1:0]         algorithm;
    logic signed [15:0] equant;
    logic [12:0]        blend;
    logic [12:0]        demod;
    logic [14:0]        gain;
    logic signed [15:0] expected_q [$];
    longint             arctan [28];

    function new();
      arctan = '{268435456, 158466703, 83729454, 42502378, 21333666, 10677233,
                 5339919, 2670123, 1335082, 667543, 333772, 166886, 83443, 41722,
                 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3};
      algorithm = ALG_CHAIN;
      equant = 0;
      blend = 0;
      demod = 0;
      gain = GAIN_RESET;
    endfunction

    function longint rnd(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint clamp_lvl(longint v);
      return v > 4096 ? 64'sd4096 : v;
    endfunction

    function longint body_sample(longint x, longint y, longint env);
      longint ax, ay, m, xn, yn, z, rn, d, q, t, dx, dy;
      longint sine, square, saw, radius, b, dm, s, mo, de;
      int n;
      y = y + equant;
      b = clamp_lvl(blend);
      dm = clamp_lvl(demod);
      if (x == 0 && y == 0) begin
        sine = 0; square = -4096; saw = -4096; radius = 0;
      end else begin
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        m = ax > ay ? ax : ay;
        n = 0;
        z = 0;
        while (m < (longint'(1) <<< 57)) begin
          m = m * 2;
          n++;
        end
        xn = x <<< n;
        yn = y <<< n;
        if (xn < 0) begin
          t = xn;
          if (yn >= 0) begin
            xn = yn; yn = -t; z = 64'sd536870912;
          end else begin
            xn = -yn; yn = t; z = -64'sd536870912;
          end
        end
        for (int i = 0; i < 28; i++) begin
          dx = yn >>> i;
          dy = xn >>> i;
          if (yn >= 0) begin
            xn += dx; yn -= dy; z += arctan[i];
          end else begin
            xn -= dx; yn += dy; z -= arctan[i];
          end
        end
        if (y == 0) z = x < 0 ? 64'sd1073741824 : 64'sd0;
        else if (x == 0) z = y > 0 ? 64'sd536870912 : -64'sd536870912;
        rn = (xn >>> 24) * 64'sd10188015;
        radius = rnd(rn, n);
        d = rn >>> 12;
        if (d <= 0) d = 1;
        q = ((ay <<< n) + d / 2) / d;
        if (q > 4096) q = 4096;
        sine = y < 0 ? -q : q;
        square = (y > 0 || (y == 0 && x < 0)) ? 64'sd4096 : -64'sd4096;
        saw = rnd(z, 17) - 4096;
      end
      if (b < 2048) s = sine * (4096 - 2 * b) + square * (2 * b);
      else s = square * (2 * (4096 - b)) + saw * (2 * (b - 2048));
      s = rnd(s, 12);
      mo = rnd(s * env, 12);
      de = rnd(s * radius * 3, 14);
      return mo * (4096 - dm) + de * dm;
    endfunction

    function void note_beat(orbit_beat_t it);
      longint bx [4], by [4], ox [4], oy [4], total, v;
      for (int i = 0; i < 4; i++) begin
        ox[i] = it.ox[i];
        oy[i] = it.oy[i];
      end
      bx[0] = ox[0]; by[0] = oy[0];
      bx[1] = bx[0] + ox[1]; by[1] = by[0] + oy[1];
      if (algorithm == ALG_CHAIN || algorithm == ALG_PAIR) begin
        bx[2] = bx[1] + ox[2]; by[2] = by[1] + oy[2];
      end else begin
        bx[2] = bx[0] + ox[2]; by[2] = by[0] + oy[2];
      end
      case (algorithm)
        ALG_CHAIN, ALG_SPLIT: begin
          bx[3] = bx[2] + ox[3]; by[3] = by[2] + oy[3];
        end
        ALG_PAIR: begin
          bx[3] = bx[1] + ox[3]; by[3] = by[1] + oy[3];
        end
        default: begin
          bx[3] = bx[0] + ox[3]; by[3] = by[0] + oy[3];
        end
      endcase
      total = body_sample(bx[3], by[3], clamp_lvl(it.env[2]));
      if (algorithm == ALG_PAIR || algorithm == ALG_STAR)
        total += body_sample(bx[2], by[2], clamp_lvl(it.env[1]));
      if (algorithm == ALG_SPLIT || algorithm == ALG_STAR)
        total += body_sample(bx[1], by[1], clamp_lvl(it.env[0]));
      v = rnd(total, 12);
      if (algorithm == ALG_PAIR || algorithm == ALG_SPLIT) v = rnd(v, 1);
      else if (algorithm == ALG_STAR) v = rnd(v * 21823, 16);
      v = rnd(v * longint'(gain), 12);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      expected_q.push_back(16'(v));
    endfunction

    // 0 ok, 1 nothing waiting, 2 wrong value
    function int check_sample(logic signed [15:0] got, output logic signed [15:0] want);
      want = 'x;
      if (expected_q.size() == 0) return 1;
      want = expected_q.pop_front();
      return (got === want) ? 0 : 2;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [15:0] osc1_x = 0, osc1_y = 0, osc2_x = 0, osc2_y = 0;
  logic signed [15:0] osc3_x = 0, osc3_y = 0, osc4_x = 0, osc4_y = 0;
  logic [LVL_W-1:0] env_level_2 = 0, env_level_3 = 0, env_level_4 = 0;
  logic cfg_we = 0;
  logic [REG_IDX_W-1:0] cfg_index = REG_ALGORITHM;
  logic [15:0] cfg_data = 0;
  logic done;
  logic signed [15:0] sample_out;

  sample_scoreboard sb = new();
  int mismatches = 0;
  bit no_idle = 0;

  epicycle_waveshaper_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .osc1_x(osc1_x), .osc1_y(osc1_y), .osc2_x(osc2_x), .osc2_y(osc2_y),
    .osc3_x(osc3_x), .osc3_y(osc3_y), .osc4_x(osc4_x), .osc4_y(osc4_y),
    .env_level_2(env_level_2), .env_level_3(env_level_3), .env_level_4(env_level_4),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .sample_out(sample_out)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(string what, logic signed [15:0] got,
                                 logic signed [15:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    logic signed [15:0] want;
    int r;
    if (!rst && done) begin
      r = sb.check_sample(sample_out, want);
      if (r == 1) report_mismatch("unexpected sample", sample_out, want);
      else if (r == 2) report_mismatch("sample_out", sample_out, want);
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_ALGORITHM: sb.algorithm = val[1:0];
      REG_EQUANT: sb.equant = val;
      REG_BLEND: sb.blend = val[12:0];
      REG_DEMOD: sb.demod = val[12:0];
      REG_GAIN: sb.gain = val[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // drive one beat and hold it until it is taken
  task automatic send_beat(orbit_beat_t it);
    int gap;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      start = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1;
    {osc1_x, osc2_x, osc3_x, osc4_x} = {it.ox[0], it.ox[1], it.ox[2], it.ox[3]};
    {osc1_y, osc2_y, osc3_y, osc4_y} = {it.oy[0], it.oy[1], it.oy[2], it.oy[3]};
    {env_level_2, env_level_3, env_level_4} = {it.env[0], it.env[1], it.env[2]};
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_beat(it);
  endtask

  task automatic stop_beats();
    @(negedge clk);
    start = 0;
  endtask

  function automatic orbit_beat_t random_beat();
    orbit_beat_t it;
    int mode;
    mode = $urandom_range(0, 4);
    for (int i = 0; i < 4; i++) begin
      case (mode)
        0, 1: begin
          it.ox[i] = 16'($urandom);
          it.oy[i] = 16'($urandom);
        end
        2: begin
          it.ox[i] = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
          it.oy[i] = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
        end
        default: begin
          it.ox[i] = $urandom_range(0, 2) == 0 ? 16'sd0 : 16'($urandom);
          it.oy[i] = $urandom_range(0, 2) == 0 ? 16'sd0 : 16'($urandom);
        end
      endcase
    end
    // cancelling pairs put chained bodies on the axes or at the origin
    if (mode == 4) begin
      it.ox[1] = -it.ox[0];
      if ($urandom_range(0, 1)) it.oy[1] = -it.oy[0];
      if ($urandom_range(0, 1)) it.ox[2] = -it.ox[0];
    end
    for (int i = 0; i < 3; i++)
      it.env[i] = $urandom_range(0, 7) == 0 ? 13'($urandom) : 13'($urandom_range(0, 4096));
    return it;
  endfunction

  function automatic orbit_beat_t flat_beat(logic signed [15:0] x, logic signed [15:0] y,
                                            logic [12:0] e);
    orbit_beat_t it;
    for (int i = 0; i < 4; i++) begin
      it.ox[i] = x;
      it.oy[i] = y;
    end
    for (int i = 0; i < 3; i++) it.env[i] = e;
    return it;
  endfunction

  initial begin
    orbit_beat_t it;
    logic [1:0] alg;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed beats at reset settings, then over every algorithm
    for (int a = 0; a < 4; a++) begin
      if (a != 0) write_reg(REG_ALGORITHM, 16'(a));
      send_beat(flat_beat(16'sh8000, 16'sh8000, 13'd4096));
      send_beat(flat_beat(16'sh7fff, 16'sh7fff, 13'h1fff));
      send_beat(flat_beat(16'sd0, 16'sd0, 13'd0));
      send_beat(flat_beat(16'sd0, 16'sd1000, 13'd4096));
      send_beat(flat_beat(-16'sd1000, 16'sd0, 13'd2048));
      it = flat_beat(16'sd1234, -16'sd777, 13'd4096);
      it.ox[1] = -16'sd1234;
      it.oy[1] = 16'sd777;
      send_beat(it);
      stop_beats();
      drain();
    end

    for (int p = 0; p < 8; p++) begin
      alg = 2'(p);
      write_reg(REG_ALGORITHM, 16'(alg));
      case (p)
        0: begin
          write_reg(REG_EQUANT, 16'h8000);
          write_reg(REG_BLEND, 16'd0);
          write_reg(REG_DEMOD, 16'd4096);
          write_reg(REG_GAIN, 16'h7fff);
        end
        1: begin
          write_reg(REG_EQUANT, 16'h7fff);
          write_reg(REG_BLEND, 16'd4096);
          write_reg(REG_DEMOD, 16'd0);
          write_reg(REG_GAIN, 16'd0);
        end
        2: begin
          write_reg(REG_EQUANT, 16'd0);
          write_reg(REG_BLEND, 16'h1fff);
          write_reg(REG_DEMOD, 16'h1fff);
          write_reg(REG_GAIN, 16'd1);
        end
        3: begin
          write_reg(REG_BLEND, 16'd2048);
          write_reg(REG_DEMOD, 16'd2048);
          write_reg(REG_GAIN, 16'd4096);
          write_reg(REG_SPARE, 16'($urandom));
        end
        default: begin
          write_reg(REG_EQUANT, 16'($urandom));
          write_reg(REG_BLEND, $urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 8191))
                                                          : 16'($urandom_range(0, 4096)));
          write_reg(REG_DEMOD, $urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 8191))
                                                          : 16'($urandom_range(0, 4096)));
          write_reg(REG_GAIN, 16'($urandom_range(0, 32767)));
        end
      endcase
      no_idle = (p == 7);
      repeat (135) send_beat(random_beat());
      stop_beats();
      drain();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
